// ----- design/ubtrf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ubtrf_pkg
// Shared types and constants of the buffered uart transmit/receive fifo unit.
// ----------------------------------------------------------------------------
package ubtrf_pkg;

  localparam int unsigned DEFAULT_FIFO_DEPTH = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OP_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ    = 2'd1;
  localparam logic [OP_W-1:0] OP_SERVICE = 2'd2;

  localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] data_in;
    logic              txe_flag;
    logic              rxne_flag;
  } in_t;

  typedef struct packed {
    logic              read_valid;
    logic [BYTE_W-1:0] read_data;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_data;
    logic              tx_irq_armed;
    logic              byte_dropped;
  } out_t;

  // request to one fifo store
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [BYTE_W-1:0] wdata;
  } fifo_req_t;

  // fifo occupancy status
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage
`default_nettype wire

// ----- design/ubtrf_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ubtrf_in_if
// Request channel into the fifo unit: valid, ready and one request.
// ----------------------------------------------------------------------------
interface ubtrf_in_if;
  import ubtrf_pkg::*;

  logic valid;
  logic ready;
  in_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- design/ubtrf_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ubtrf_out_if
// Result channel out of the fifo unit: valid, ready and one result.
// ----------------------------------------------------------------------------
interface ubtrf_out_if;
  import ubtrf_pkg::*;

  logic valid;
  logic ready;
  out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- design/ubtrf_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ubtrf_fifo
// Byte fifo built on a synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module ubtrf_fifo import ubtrf_pkg::*; #(
  parameter int unsigned DEPTH = DEFAULT_FIFO_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fifo_req_t         req_i,
  output      fifo_stat_t        stat_o,
  output      logic [BYTE_W-1:0] rdata_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (req_i.push) begin
      tail_d = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
    end
    if (req_i.pop) begin
      head_d = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
    end
    if (req_i.push && !req_i.pop) begin
      count_d = count_q + 1'b1;
    end else if (req_i.pop && !req_i.push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem[tail_q] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.pop) begin
      rdata_q <= mem[head_q];
    end
  end

  assign rdata_o      = rdata_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CNT_FULL);

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full && !req_i.pop |-> !req_i.push)
    else $error("push into full fifo");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.empty |-> !req_i.pop)
    else $error("pop from empty fifo");

  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.push && !req_i.pop |=> count_q == $past(count_q) + 1'b1)
    else $error("fifo count did not follow push");
`endif

endmodule
`default_nettype wire

// ----- design/uart_buffered_tx_rx_fifo_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uart_buffered_tx_rx_fifo_unit
// Buffered uart front end: a transmit fifo and a receive fifo serviced by
// software writes, software reads and interrupt service events.
//
// Channels: in_i carries one request (operation, data_in, txe_flag,
// rxne_flag); out_o returns exactly one result per request, in order.
// Each fifo lives in a synchronous memory with a registered read port.
// A request is decoded at acceptance: pointers, counts and the interrupt
// enable update and the memory write or read starts in that cycle. The
// read data is then held in the memory read register, and the result is
// loaded into the output register once the output register is free.
// One request is accepted per cycle while results are being taken.
// When out_o stalls, the output register holds its result and the middle
// stage holds the next one; in_i ready drops until the output drains.
// Reset clears pointers, counts, the interrupt enable and all valid flags;
// fifo memory contents are not cleared and are never read before written.
// ----------------------------------------------------------------------------
module uart_buffered_tx_rx_fifo_unit import ubtrf_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ubtrf_in_if.sink    in_i,
  ubtrf_out_if.source out_o
);

  fifo_req_t  tx_req, rx_req;
  fifo_stat_t tx_stat, rx_stat;
  logic [BYTE_W-1:0] tx_rdata, rx_rdata;

  logic accept;
  logic s1_done;
  logic irq_q, irq_d;
  logic s1_valid_q, s1_valid_d;
  logic s1_rv_q, s1_rv_d;
  logic s1_tv_q, s1_tv_d;
  logic s1_irq_q;
  logic s1_drop_q, s1_drop_d;
  logic out_valid_q, out_valid_d;
  out_t out_q;

  assign s1_done    = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_done;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    tx_req    = '{push: 1'b0, pop: 1'b0, wdata: in_i.payload.data_in};
    rx_req    = '{push: 1'b0, pop: 1'b0, wdata: in_i.payload.data_in};
    irq_d     = irq_q;
    s1_rv_d   = 1'b0;
    s1_tv_d   = 1'b0;
    s1_drop_d = 1'b0;
    if (accept) begin
      unique case (in_i.payload.operation)
        OP_WRITE: begin
          tx_req.push = !tx_stat.full;
          s1_drop_d   = tx_stat.full;
          irq_d       = 1'b1;
        end
        OP_READ: begin
          rx_req.pop = !rx_stat.empty;
          s1_rv_d    = !rx_stat.empty;
        end
        OP_SERVICE: begin
          if (in_i.payload.txe_flag) begin
            if (!tx_stat.empty) begin
              tx_req.pop = 1'b1;
              s1_tv_d    = 1'b1;
            end else begin
              irq_d = 1'b0;
            end
          end
          if (in_i.payload.rxne_flag) begin
            rx_req.push = !rx_stat.full;
            s1_drop_d   = rx_stat.full;
          end
        end
        default: begin
          // unused code, nothing changes
        end
      endcase
    end
  end

  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_done) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    if (s1_valid_q && s1_done) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      irq_q       <= irq_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rv_q   <= s1_rv_d;
      s1_tv_q   <= s1_tv_d;
      s1_irq_q  <= irq_d;
      s1_drop_q <= s1_drop_d;
    end
  end

  // read data is back from memory here
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_done) begin
      out_q.read_valid   <= s1_rv_q;
      out_q.read_data    <= s1_rv_q ? rx_rdata : BYTE_ZERO;
      out_q.tx_valid     <= s1_tv_q;
      out_q.tx_data      <= s1_tv_q ? tx_rdata : BYTE_ZERO;
      out_q.tx_irq_armed <= s1_irq_q;
      out_q.byte_dropped <= s1_drop_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  ubtrf_fifo #(.DEPTH(FIFO_DEPTH)) u_tx_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tx_req),
    .stat_o (tx_stat),
    .rdata_o(tx_rdata)
  );

  ubtrf_fifo #(.DEPTH(FIFO_DEPTH)) u_rx_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rx_req),
    .stat_o (rx_stat),
    .rdata_o(rx_rdata)
  );

`ifndef SYNTHESIS
  a_write_arms_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.payload.operation == OP_WRITE |=> irq_q)
    else $error("write request did not arm the interrupt enable");

  a_read_and_tx_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> !(s1_rv_q && s1_tv_q))
    else $error("one request both read and transmitted");

  a_read_not_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.read_valid && out_q.byte_dropped))
    else $error("read result flagged as dropped");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_done |=> out_valid_q)
    else $error("middle stage lost its result");
`endif

endmodule
`default_nettype wire
